[rtl/core/cms_pkg.sv]
// Shared types, widths and codes for the min/max contrast stretch block.
// Depends on nothing; every other file in rtl/core imports it.
`timescale 1ns / 1ps

package cms_pkg;

  // Sample field and the bits of it that carry the value
  localparam int SAMPLE_W    = 16;
  localparam int SAMPLE_BITS = 16;

  // Derived datapath widths
  localparam int DIFF_W  = SAMPLE_BITS + 1;  // s - seq_min, signed
  localparam int RANGE_W = SAMPLE_BITS;      // seq_max - seq_min, unsigned
  localparam int LEVEL_W = 8;
  localparam int DIF_W   = LEVEL_W + 1;      // out_max - out_min, signed
  localparam int PROD_W  = DIFF_W + DIF_W;   // offset product, signed
  localparam int BASE_W  = RANGE_W + LEVEL_W; // out_min * range, unsigned
  localparam int NUM_W   = PROD_W + 1;       // numerator, signed
  localparam int REM_W   = RANGE_W + LEVEL_W; // partial remainder
  localparam int QCNT_W  = $clog2(LEVEL_W);

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Constants of the mapping
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = '1;
  localparam logic [RANGE_W-1:0] FLAT_RANGE  = RANGE_W'(2);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX = 1'b1;

  // One scale request with the measured statistics it saw on arrival
  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic [RANGE_W-1:0]       span;
    logic                     last;
  } cms_job_t;

  // Back end sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_RND
  } cms_state_t;

endpackage

[rtl/core/cms_front.sv]
// Front end: accepts requests, tracks running min/max on measure requests
// and turns each scale request into a job for the back end. Uses cms_pkg.
`timescale 1ns / 1ps

module cms_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cms_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                          in_scale,
  input  logic                          in_first,
  input  logic                          in_last,
  output logic                          job_valid,
  input  logic                          job_ready,
  output cms_pkg::cms_job_t             job
);
  import cms_pkg::*;

  logic signed [SAMPLE_BITS-1:0] seq_min;
  logic signed [SAMPLE_BITS-1:0] seq_max;
  logic signed [SAMPLE_BITS-1:0] s;
  logic                          accept;

  assign s        = $signed(in_sample[SAMPLE_BITS-1:0]);
  assign in_ready = job_ready;
  assign accept   = in_valid & in_ready;

  // Update running statistics on measure requests
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_min <= '0;
      seq_max <= '0;
    end else if (accept && !in_scale) begin
      if (in_first) begin
        seq_min <= s;
        seq_max <= s;
      end else if (s > seq_max) begin
        seq_max <= s;
      end else if (s < seq_min) begin
        seq_min <= s;
      end
    end
  end

  // Snapshot offset and range for scale requests
  always_comb begin
    job.diff = DIFF_W'(s) - DIFF_W'(seq_min);
    if (seq_max > seq_min) begin
      job.span = RANGE_W'(DIFF_W'(seq_max) - DIFF_W'(seq_min));
    end else begin
      job.span = FLAT_RANGE;
    end
    job.last  = in_last;
    job_valid = in_valid & in_scale;
  end

endmodule

[rtl/core/cms_queue.sv]
// Short job queue decoupling the front end from the back end.
// Uses cms_pkg for the job type and depth.
`timescale 1ns / 1ps

module cms_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  cms_pkg::cms_job_t push_job,
  output logic              pop_valid,
  input  logic              pop_ready,
  output cms_pkg::cms_job_t pop_job
);
  import cms_pkg::*;

  cms_job_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign push_ready = (count != (QPTR_W + 1)'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;
  assign pop_job    = slots[rd_ptr];

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W + 1)'(QDEPTH))
    else $error("queue occupancy beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue occupancy did not follow a lone push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    wr_ptr - rd_ptr == count[QPTR_W-1:0])
    else $error("queue pointers disagree with occupancy");

endmodule

[rtl/core/cms_back.sv]
// Back end: scales one job at a time with a restoring divider, rounds,
// saturates and holds the level in an output register. Uses cms_pkg.
`timescale 1ns / 1ps

module cms_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [cms_pkg::LEVEL_W-1:0] out_min,
  input  logic [cms_pkg::LEVEL_W-1:0] out_max,
  input  logic                        job_valid,
  output logic                        job_ready,
  input  cms_pkg::cms_job_t           job,
  output logic                        m_valid,
  input  logic                        m_ready,
  output logic [cms_pkg::LEVEL_W-1:0] m_level,
  output logic                        m_last
);
  import cms_pkg::*;

  cms_state_t               state;
  cms_state_t               state_next;
  cms_job_t                 cur;
  logic [BASE_W-1:0]        p_base;
  logic signed [PROD_W-1:0] p_off;
  logic signed [NUM_W-1:0]  num;
  logic [REM_W-1:0]         rem;
  logic [REM_W-1:0]         dvs;
  logic [REM_W-1:0]         bound;
  logic [LEVEL_W-1:0]       quo;
  logic [LEVEL_W-1:0]       level_fin;
  logic [QCNT_W-1:0]        cnt;
  logic                     direct;
  logic                     ge;
  logic                     round_up;
  logic                     out_free;
  logic                     load_out;
  logic signed [DIF_W-1:0]  dif;
  logic signed [DIFF_W-1:0] cur_diff;

  assign dif      = $signed({1'b0, out_max}) - $signed({1'b0, out_min});
  assign cur_diff = cur.diff;
  assign num      = NUM_W'($signed({1'b0, p_base})) + NUM_W'(p_off);
  assign bound    = {cur.span, LEVEL_W'(0)};
  assign ge       = (rem >= dvs);
  assign round_up = ({rem[RANGE_W-1:0], 1'b0} > {1'b0, cur.span});
  assign out_free = !m_valid || m_ready;

  always_comb begin
    if (direct) begin
      level_fin = quo;
    end else if (round_up && quo != LEVEL_MAX) begin
      level_fin = quo + 1'b1;
    end else begin
      level_fin = quo;
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_SUM;
      ST_SUM: begin
        if (num < 0 || num[NUM_W-2:0] >= (NUM_W - 1)'(bound)) begin
          state_next = ST_RND;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == '0) begin
          state_next = ST_RND;
        end
      end
      ST_RND: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath: products, numerator check, one quotient bit a cycle
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          cur <= job;
        end
      end
      ST_MUL: begin
        p_base <= BASE_W'(out_min) * BASE_W'(cur.span);
        p_off  <= PROD_W'(cur_diff) * PROD_W'(dif);
      end
      ST_SUM: begin
        rem <= num[REM_W-1:0];
        dvs <= REM_W'(cur.span) << (LEVEL_W - 1);
        cnt <= QCNT_W'(LEVEL_W - 1);
        if (num < 0) begin
          quo    <= '0;
          direct <= 1'b1;
        end else if (num[NUM_W-2:0] >= (NUM_W - 1)'(bound)) begin
          quo    <= LEVEL_MAX;
          direct <= 1'b1;
        end else begin
          quo    <= '0;
          direct <= 1'b0;
        end
      end
      ST_DIV: begin
        if (ge) begin
          rem <= rem - dvs;
        end
        quo <= {quo[LEVEL_W-2:0], ge};
        dvs <= dvs >> 1;
        cnt <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load_out) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_level <= level_fin;
      m_last  <= cur.last;
    end
  end

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt == '0) |=> state == ST_RND)
    else $error("divider did not finish after the last quotient bit");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("output register overwritten while full");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    job_ready |-> state == ST_IDLE)
    else $error("job taken while a scale was in progress");

endmodule

[rtl/core/min_max_contrast_stretch.sv]
// Top level of the min/max contrast stretch block: configuration registers,
// front end, job queue and back end. Uses cms_pkg and the cms_* modules.
`timescale 1ns / 1ps

// Measure requests (tuser[0] low) update the running minimum and maximum and
// are taken one per clock while the job queue has room; tuser[1] on a measure
// request reloads both from its sample. Scale requests (tuser[0] high) return
// one byte level each, out_min + (s - min) * (out_max - out_min) / range,
// rounded up only above one half and clamped to 0..255, with tlast copied
// through. In the back end each scale request passes through pop, multiply,
// sum, a one-bit-per-cycle restoring divider and round; the divider is
// skipped when the numerator is negative or at least 256 times the range,
// and the round step waits while the result stream keeps the output register
// full; a four-entry queue lets the front keep taking requests meanwhile. Write
// out_min and out_max only while no request is in flight.
module min_max_contrast_stretch (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cms_pkg::LEVEL_W-1:0]   cfg_data,
  // request stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // [15:0] sample
  input  logic [1:0]                    s_tuser,   // [0] req_type, [1] first_sample
  input  logic                          s_tlast,
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [7:0] level
  output logic                          m_tlast    // end_mark
);
  import cms_pkg::*;

  logic [LEVEL_W-1:0] out_min;
  logic [LEVEL_W-1:0] out_max;
  logic               q_push_valid;
  logic               q_push_ready;
  cms_job_t           q_push_job;
  logic               q_pop_valid;
  logic               q_pop_ready;
  cms_job_t           q_pop_job;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_min <= '0;
      out_max <= LEVEL_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OUT_MIN: out_min <= cfg_data;
        CFG_OUT_MAX: out_max <= cfg_data;
        default: ;
      endcase
    end
  end

  cms_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_sample (s_tdata[SAMPLE_W-1:0]),
    .in_scale  (s_tuser[0]),
    .in_first  (s_tuser[1]),
    .in_last   (s_tlast),
    .job_valid (q_push_valid),
    .job_ready (q_push_ready),
    .job       (q_push_job)
  );

  cms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_job   (q_push_job),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_job    (q_pop_job)
  );

  cms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .out_min   (out_min),
    .out_max   (out_max),
    .job_valid (q_pop_valid),
    .job_ready (q_pop_ready),
    .job       (q_pop_job),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_level   (m_tdata),
    .m_last    (m_tlast)
  );

endmodule
